// File: design/mtt_pkg.sv
// Package for the message timer table: sizes, command/result codes,
// entry record and state encoding. No dependencies.
package mtt_pkg;

  localparam int unsigned TIMERS  = 16;
  localparam int unsigned TICK_MS = 1;
  localparam int unsigned IDX_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  typedef enum logic [2:0] {
    CMD_TICK         = 3'd0,
    CMD_SEND         = 3'd1,
    CMD_RESEND       = 3'd2,
    CMD_CANCEL_FIRST = 3'd3,
    CMD_CANCEL_ALL   = 3'd4,
    CMD_FLUSH        = 3'd5,
    CMD_QUERY_REM    = 3'd6,
    CMD_QUERY_PRES   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_DONE    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_STOPPED  = 2'd1,
    ST_NO_TIMER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_LAST
  } state_e;

  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] message;
    logic [32:0] argument;
    logic [31:0] period;
    logic [31:0] match;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  process;
    logic [15:0] msg;
    logic [31:0] arg;
  } result_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// File: design/mtt_cmd_if.sv
// Command channel of the message timer table.
// Depends on mtt_pkg.
interface mtt_cmd_if;
  logic               valid;
  logic               ready;
  mtt_pkg::cmd_e      command;
  logic [7:0]         process_id;
  logic               process_running;
  logic [15:0]        msg_id;
  logic [31:0]        arg_handle;
  logic               arg_present;
  logic [31:0]        delay_ms;
  logic [31:0]        period_ms;

  modport source (output valid, command, process_id, process_running, msg_id,
                  arg_handle, arg_present, delay_ms, period_ms, input ready);
  modport sink   (input valid, command, process_id, process_running, msg_id,
                  arg_handle, arg_present, delay_ms, period_ms, output ready);
endinterface

// File: design/mtt_res_if.sv
// Result channel of the message timer table.
// Depends on mtt_pkg.
interface mtt_res_if;
  logic               valid;
  logic               ready;
  mtt_pkg::kind_e     kind;
  logic [7:0]         out_process;
  logic [15:0]        out_msg;
  logic [31:0]        out_arg;
  mtt_pkg::status_e   status;
  logic [31:0]        remaining_ticks;
  logic               found;
  logic               last;

  modport source (output valid, kind, out_process, out_msg, out_arg, status,
                  remaining_ticks, found, last, input ready);
  modport sink   (input valid, kind, out_process, out_msg, out_arg, status,
                  remaining_ticks, found, last, output ready);
endinterface

// File: design/mtt_entry_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module mtt_entry_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: design/message_timer_table_core.sv
// Message timer table: timer entries held in mtt_entry_ram, scanned once per
// command by a read-modify-write scan of one entry per cycle while the result
// side does not stall. One command in flight; the next is taken once the last
// beat leaves.
// Reset clears tick count and entry valid flags at once; no clearing pass.
// Depends on mtt_pkg, mtt_cmd_if, mtt_res_if, mtt_entry_ram.
module message_timer_table_core (
  input  logic clk_i,
  input  logic rst_ni,
  mtt_cmd_if.sink   cmd_i,
  mtt_res_if.source res_o
);

  typedef logic [mtt_pkg::IDX_W-1:0] idx_t;

  mtt_pkg::state_e  state_q, state_d;
  idx_t             idx_q, idx_d;
  logic [31:0]      tick_q, tick_d;
  logic [mtt_pkg::TIMERS-1:0] valid_q, valid_d;

  mtt_pkg::cmd_e    c_q;
  logic [7:0]       proc_q;
  logic             run_q;
  logic [15:0]      msg_q;
  logic [31:0]      handle_q;
  logic             hasarg_q;
  logic             dzero_q;
  logic [31:0]      dticks_q;
  logic [31:0]      pticks_q;

  logic             first_done_q, first_done_d;
  logic             free_found_q, free_found_d;
  idx_t             free_idx_q, free_idx_d;
  logic             qhit_q, qhit_d;
  logic [31:0]      rem_q, rem_d;
  mtt_pkg::status_e status_q, status_d;

  logic             pend_valid_q, pend_valid_d;
  mtt_pkg::result_t pend_q, pend_d;

  logic             out_valid_q, out_valid_d;
  mtt_pkg::result_t out_q, out_d;
  logic             out_last_q, out_last_d;

  logic             rd_en, we;
  idx_t             rd_addr, wr_addr;
  mtt_pkg::entry_t  rdata, wdata;
  logic [mtt_pkg::ENTRY_W-1:0] rdata_raw;

  mtt_entry_ram #(
    .Width (mtt_pkg::ENTRY_W),
    .Depth (mtt_pkg::TIMERS),
    .AddrW (mtt_pkg::IDX_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wdata_i   (wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rdata_o   (rdata_raw)
  );
  assign rdata = mtt_pkg::entry_t'(rdata_raw);

  logic accept, can_push;
  logic v, own, mmatch, is_cancel, cancel_hit, tick_hit, is_send;
  logic produce, stall, push, push_last;
  mtt_pkg::result_t res_new, push_data;
  logic [31:0] dclamp;

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign can_push = !out_valid_q || res_o.ready;
  // status, remaining and found are shared by all beats: wait for the last one
  assign cmd_i.ready = (state_q == mtt_pkg::S_IDLE) && can_push;

  assign v      = valid_q[idx_q];
  assign own    = v && (rdata.owner == proc_q);
  assign mmatch = own && (rdata.message == msg_q);
  assign is_send = (c_q == mtt_pkg::CMD_SEND) || (c_q == mtt_pkg::CMD_RESEND);
  assign is_cancel = (c_q == mtt_pkg::CMD_RESEND) || (c_q == mtt_pkg::CMD_CANCEL_FIRST) ||
                     (c_q == mtt_pkg::CMD_CANCEL_ALL) || (c_q == mtt_pkg::CMD_FLUSH);
  assign cancel_hit = is_cancel && ((c_q == mtt_pkg::CMD_FLUSH) ? own : mmatch) &&
                      !((c_q == mtt_pkg::CMD_CANCEL_FIRST) && first_done_q);
  assign tick_hit = (c_q == mtt_pkg::CMD_TICK) && v && (rdata.match == tick_q);

  assign dclamp = (cmd_i.delay_ms < 32'(mtt_pkg::TICK_MS)) ? 32'(mtt_pkg::TICK_MS)
                                                            : cmd_i.delay_ms;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mtt_pkg::S_IDLE: if (accept) state_d = mtt_pkg::S_SCAN;
      mtt_pkg::S_SCAN: if (!stall && idx_q == idx_t'(mtt_pkg::TIMERS - 1)) begin
        state_d = mtt_pkg::S_FIN;
      end
      mtt_pkg::S_FIN:  if (!stall) state_d = mtt_pkg::S_LAST;
      mtt_pkg::S_LAST: if (can_push) state_d = mtt_pkg::S_IDLE;
      default:         state_d = mtt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idx_d        = idx_q;
    tick_d       = tick_q;
    valid_d      = valid_q;
    first_done_d = first_done_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    qhit_d       = qhit_q;
    rem_d        = rem_q;
    status_d     = status_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q;
    we           = 1'b0;
    wr_addr      = idx_q;
    wdata        = rdata;
    produce      = 1'b0;
    res_new      = '{kind: mtt_pkg::KIND_DONE, process: 8'd0, msg: 16'd0, arg: 32'd0};
    push         = 1'b0;
    push_last    = 1'b0;
    push_data    = pend_q;

    case (state_q)
      mtt_pkg::S_IDLE: begin
        if (accept) begin
          idx_d        = '0;
          rd_en        = 1'b1;
          rd_addr      = '0;
          first_done_d = 1'b0;
          free_found_d = 1'b0;
          qhit_d       = 1'b0;
          rem_d        = '0;
          pend_valid_d = 1'b0;
          status_d     = ((cmd_i.command == mtt_pkg::CMD_SEND ||
                           cmd_i.command == mtt_pkg::CMD_RESEND) && !cmd_i.process_running)
                         ? mtt_pkg::ST_STOPPED : mtt_pkg::ST_OK;
          if (cmd_i.command == mtt_pkg::CMD_TICK) tick_d = tick_q + 32'd1;
        end
      end
      mtt_pkg::S_SCAN: begin
        if (tick_hit) begin
          produce = 1'b1;
          res_new = '{kind: mtt_pkg::KIND_DELIVER, process: rdata.owner,
                      msg: rdata.message,
                      arg: rdata.argument[32] ? rdata.argument[31:0] : 32'd0};
        end else if (cancel_hit && rdata.argument[32]) begin
          produce = 1'b1;
          res_new = '{kind: mtt_pkg::KIND_RELEASE, process: rdata.owner,
                      msg: rdata.message, arg: rdata.argument[31:0]};
        end
      end
      mtt_pkg::S_FIN: begin
        if (is_send) begin
          if (!run_q) begin
            produce = hasarg_q;
            res_new = '{kind: mtt_pkg::KIND_RELEASE, process: proc_q, msg: msg_q,
                        arg: handle_q};
          end else if (dzero_q) begin
            produce = 1'b1;
            res_new = '{kind: mtt_pkg::KIND_DELIVER, process: proc_q, msg: msg_q,
                        arg: hasarg_q ? handle_q : 32'd0};
          end
        end
      end
      mtt_pkg::S_LAST: begin
        if (can_push) begin
          push      = 1'b1;
          push_last = 1'b1;
          push_data = pend_valid_q ? pend_q : res_new;
        end
      end
      default: ;
    endcase

    stall = produce && pend_valid_q && !can_push;

    if (produce && !stall) begin
      if (pend_valid_q) begin
        push      = 1'b1;
        push_data = pend_q;
      end
      pend_valid_d = 1'b1;
      pend_d       = res_new;
    end

    if (state_q == mtt_pkg::S_SCAN && !stall) begin
      if (idx_q != idx_t'(mtt_pkg::TIMERS - 1)) begin
        idx_d   = idx_q + idx_t'(1);
        rd_en   = 1'b1;
        rd_addr = idx_q + idx_t'(1);
      end
      if (tick_hit) begin
        if (rdata.period != 32'd0) begin
          we          = 1'b1;
          wdata.match = tick_q + rdata.period;
        end else begin
          valid_d[idx_q] = 1'b0;
        end
      end
      if (cancel_hit) begin
        valid_d[idx_q] = 1'b0;
        first_done_d   = 1'b1;
      end
      if (is_send && !free_found_q && (!v || cancel_hit)) begin
        free_found_d = 1'b1;
        free_idx_d   = idx_q;
      end
      if (((c_q == mtt_pkg::CMD_QUERY_REM) || (c_q == mtt_pkg::CMD_QUERY_PRES)) &&
          mmatch && !qhit_q) begin
        qhit_d = 1'b1;
        if (c_q == mtt_pkg::CMD_QUERY_REM) rem_d = rdata.match - tick_q;
      end
    end

    if (state_q == mtt_pkg::S_FIN && !stall && is_send && run_q && !dzero_q) begin
      if (free_found_q) begin
        we                  = 1'b1;
        wr_addr             = free_idx_q;
        wdata.owner         = proc_q;
        wdata.message       = msg_q;
        wdata.argument      = {hasarg_q, handle_q};
        wdata.period        = pticks_q;
        wdata.match         = tick_q + dticks_q;
        valid_d[free_idx_q] = 1'b1;
      end else begin
        status_d = mtt_pkg::ST_NO_TIMER;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_data;
      out_last_d  = push_last;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mtt_pkg::S_IDLE;
      tick_q       <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      tick_q       <= tick_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    first_done_q <= first_done_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    qhit_q       <= qhit_d;
    rem_q        <= rem_d;
    status_q     <= status_d;
    pend_q       <= pend_d;
    out_q        <= out_d;
    out_last_q   <= out_last_d;
    if (accept) begin
      c_q      <= cmd_i.command;
      proc_q   <= cmd_i.process_id;
      run_q    <= cmd_i.process_running;
      msg_q    <= cmd_i.msg_id;
      handle_q <= cmd_i.arg_handle;
      hasarg_q <= cmd_i.arg_present;
      dzero_q  <= (cmd_i.delay_ms == 32'd0);
      dticks_q <= dclamp / mtt_pkg::TICK_MS;
      pticks_q <= cmd_i.period_ms / mtt_pkg::TICK_MS;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.kind            = out_q.kind;
  assign res_o.out_process     = out_q.process;
  assign res_o.out_msg         = out_q.msg;
  assign res_o.out_arg         = out_q.arg;
  assign res_o.status          = status_q;
  assign res_o.remaining_ticks = rem_q;
  assign res_o.found           = qhit_q && (c_q == mtt_pkg::CMD_QUERY_PRES);
  assign res_o.last            = out_last_q;

endmodule

// File: test/message_timer_table_core_test.sv
// Self-checking bench for message_timer_table_core: random and directed timer
// commands, a behavioral timer pool predicts every result beat.
// Depends on mtt_pkg, mtt_cmd_if, mtt_res_if and the core.
module message_timer_table_core_test;
  import mtt_pkg::*;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  process_id;
    logic        process_running;
    logic [15:0] msg_id;
    logic [31:0] arg_handle;
    logic        arg_present;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_process;
    logic [15:0] out_msg;
    logic [31:0] out_arg;
    status_e     status;
    logic [31:0] remaining_ticks;
    logic        found;
    logic        last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  mtt_cmd_if cmd_bus ();
  mtt_res_if res_bus ();

  message_timer_table_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus.sink),
    .res_o  (res_bus.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cmd_t  pending_cmds[$];
  beat_t expected_beats[$];
  int    errors = 0;
  bit    calm = 1'b0;
  bit    hold_send = 1'b0;

  // timer pool image
  logic [31:0] tick_now;
  logic        tv[TIMERS];
  logic [7:0]  town[TIMERS];
  logic [15:0] tmsg[TIMERS];
  logic [32:0] targ[TIMERS];
  logic [31:0] tper[TIMERS];
  logic [31:0] tmat[TIMERS];
  beat_t       step_beats[$];

  task automatic push_beat(kind_e k, logic [7:0] p, logic [15:0] m, logic [31:0] a);
    beat_t b;
    b = '0;
    b.kind = k; b.out_process = p; b.out_msg = m; b.out_arg = a;
    step_beats.push_back(b);
  endtask

  task automatic free_timer(int i);
    tv[i] = 1'b0;
    if (targ[i][32]) push_beat(KIND_RELEASE, town[i], tmsg[i], targ[i][31:0]);
  endtask

  task automatic cancel_timers(logic [7:0] p, logic [15:0] m, bit first, bit any);
    for (int i = 0; i < TIMERS; i++) begin
      if (tv[i] && town[i] == p && (any || tmsg[i] == m)) begin
        free_timer(i);
        if (first) break;
      end
    end
  endtask

  function automatic int first_timer(logic [7:0] p, logic [15:0] m);
    for (int i = 0; i < TIMERS; i++)
      if (tv[i] && town[i] == p && tmsg[i] == m) return i;
    return -1;
  endfunction

  task automatic predict_timer_cmd(cmd_t c);
    status_e     st;
    logic [31:0] rem;
    logic        fnd;
    logic [31:0] d;
    int          i;
    st = ST_OK; rem = '0; fnd = 1'b0;
    step_beats.delete();
    case (c.command)
      CMD_TICK: begin
        tick_now = tick_now + 32'd1;
        for (i = 0; i < TIMERS; i++) begin
          if (tv[i] && tmat[i] == tick_now) begin
            push_beat(KIND_DELIVER, town[i], tmsg[i], targ[i][32] ? targ[i][31:0] : 32'd0);
            if (tper[i] != 0) tmat[i] = tick_now + tper[i];
            else tv[i] = 1'b0;
          end
        end
      end
      CMD_SEND, CMD_RESEND: begin
        if (c.command == CMD_RESEND) cancel_timers(c.process_id, c.msg_id, 0, 0);
        if (!c.process_running) begin
          if (c.arg_present) push_beat(KIND_RELEASE, c.process_id, c.msg_id, c.arg_handle);
          st = ST_STOPPED;
        end else if (c.delay_ms == 0) begin
          push_beat(KIND_DELIVER, c.process_id, c.msg_id,
                    c.arg_present ? c.arg_handle : 32'd0);
        end else begin
          d = (c.delay_ms < TICK_MS) ? TICK_MS : c.delay_ms;
          for (i = 0; i < TIMERS; i++) if (!tv[i]) break;
          if (i >= TIMERS) st = ST_NO_TIMER;
          else begin
            tv[i] = 1'b1; town[i] = c.process_id; tmsg[i] = c.msg_id;
            targ[i] = {c.arg_present, c.arg_handle};
            tper[i] = c.period_ms / TICK_MS;
            tmat[i] = tick_now + d / TICK_MS;
          end
        end
      end
      CMD_CANCEL_FIRST: cancel_timers(c.process_id, c.msg_id, 1, 0);
      CMD_CANCEL_ALL:   cancel_timers(c.process_id, c.msg_id, 0, 0);
      CMD_FLUSH:        cancel_timers(c.process_id, c.msg_id, 0, 1);
      CMD_QUERY_REM: begin
        i = first_timer(c.process_id, c.msg_id);
        if (i >= 0) rem = tmat[i] - tick_now;
      end
      default: fnd = (first_timer(c.process_id, c.msg_id) >= 0);
    endcase
    if (step_beats.size() == 0) push_beat(KIND_DONE, '0, '0, '0);
    foreach (step_beats[k]) begin
      step_beats[k].status = st;
      step_beats[k].remaining_ticks = rem;
      step_beats[k].found = fnd;
      step_beats[k].last = (k == step_beats.size() - 1);
      expected_beats.push_back(step_beats[k]);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 19);
  endfunction

  // driver
  initial begin
    cmd_bus.valid = 1'b0;
    cmd_bus.command = CMD_TICK;
    cmd_bus.process_id = '0; cmd_bus.process_running = 1'b0; cmd_bus.msg_id = '0;
    cmd_bus.arg_handle = '0; cmd_bus.arg_present = 1'b0;
    cmd_bus.delay_ms = '0; cmd_bus.period_ms = '0;
    res_bus.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cmd_t c;
    if (rst_ni) begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        c.command = cmd_bus.command; c.process_id = cmd_bus.process_id;
        c.process_running = cmd_bus.process_running; c.msg_id = cmd_bus.msg_id;
        c.arg_handle = cmd_bus.arg_handle; c.arg_present = cmd_bus.arg_present;
        c.delay_ms = cmd_bus.delay_ms; c.period_ms = cmd_bus.period_ms;
        predict_timer_cmd(c);
      end
      if (!(cmd_bus.valid && !cmd_bus.ready)) begin
        if (pending_cmds.size() != 0 && !hold_send && !idle_now()) begin
          c = pending_cmds.pop_front();
          cmd_bus.valid <= 1'b1;
          cmd_bus.command <= c.command; cmd_bus.process_id <= c.process_id;
          cmd_bus.process_running <= c.process_running; cmd_bus.msg_id <= c.msg_id;
          cmd_bus.arg_handle <= c.arg_handle; cmd_bus.arg_present <= c.arg_present;
          cmd_bus.delay_ms <= c.delay_ms; cmd_bus.period_ms <= c.period_ms;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    beat_t w;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", res_bus.kind, 0);
        end else begin
          w = expected_beats.pop_front();
          if (res_bus.kind !== w.kind) report_mismatch("kind", res_bus.kind, w.kind);
          if (res_bus.out_process !== w.out_process)
            report_mismatch("out_process", res_bus.out_process, w.out_process);
          if (res_bus.out_msg !== w.out_msg) report_mismatch("out_msg", res_bus.out_msg, w.out_msg);
          if (res_bus.out_arg !== w.out_arg) report_mismatch("out_arg", res_bus.out_arg, w.out_arg);
          if (res_bus.status !== w.status) report_mismatch("status", res_bus.status, w.status);
          if (res_bus.remaining_ticks !== w.remaining_ticks)
            report_mismatch("remaining_ticks", res_bus.remaining_ticks, w.remaining_ticks);
          if (res_bus.found !== w.found) report_mismatch("found", res_bus.found, w.found);
          if (res_bus.last !== w.last) report_mismatch("last", res_bus.last, w.last);
        end
      end
      res_bus.ready <= !idle_now();
    end
  end

  function automatic cmd_t mk(cmd_e op, logic [7:0] p, logic run, logic [15:0] m,
                              logic [31:0] a, logic ap, logic [31:0] d, logic [31:0] per);
    cmd_t c;
    c.command = op; c.process_id = p; c.process_running = run; c.msg_id = m;
    c.arg_handle = a; c.arg_present = ap; c.delay_ms = d; c.period_ms = per;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   r;
    c.command = cmd_e'($urandom_range(7));
    r = $urandom_range(99);
    if (r < 35) c.command = CMD_TICK;
    else if (r < 60) c.command = CMD_SEND;
    c.process_id = 8'(($urandom_range(9) == 0) ? $urandom : $urandom_range(3));
    c.process_running = ($urandom_range(9) != 0);
    c.msg_id = 16'(($urandom_range(9) == 0) ? $urandom : $urandom_range(3));
    c.arg_handle = $urandom;
    c.arg_present = 1'($urandom_range(1));
    r = $urandom_range(9);
    c.delay_ms = (r == 0) ? 32'd0 : (r == 1) ? $urandom : $urandom_range(1, 6);
    r = $urandom_range(9);
    c.period_ms = (r < 5) ? 32'd0 : (r == 5) ? $urandom : $urandom_range(1, 5);
    return c;
  endfunction

  initial begin
    int guard;
    for (int i = 0; i < TIMERS; i++) tv[i] = 1'b0;
    tick_now = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_cmds.push_back(mk(CMD_QUERY_PRES, 8'd0, 1, 16'd0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_SEND, 8'hFF, 0, 16'hFFFF, 32'hFFFFFFFF, 1, 5, 0));
    pending_cmds.push_back(mk(CMD_SEND, 8'h01, 0, 16'h0001, 32'h1, 0, 5, 0));
    pending_cmds.push_back(mk(CMD_SEND, 8'h02, 1, 16'h0002, 32'hA5A5A5A5, 1, 0, 7));
    pending_cmds.push_back(mk(CMD_SEND, 8'h02, 1, 16'h0003, 32'h0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_SEND, 8'h03, 1, 16'h0004, 32'h12345678, 1, 2, 3));
    pending_cmds.push_back(mk(CMD_SEND, 8'h03, 1, 16'h0004, 32'h5A5A5A5A, 0, 32'hFFFFFFFF,
                              32'hFFFFFFFF));
    pending_cmds.push_back(mk(CMD_QUERY_REM, 8'h03, 1, 16'h0004, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_QUERY_PRES, 8'h03, 1, 16'h0004, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_QUERY_REM, 8'hAA, 1, 16'h5555, 0, 0, 0, 0));
    for (int i = 0; i < TIMERS + 1; i++)
      pending_cmds.push_back(mk(CMD_SEND, 8'h10, 1, i[15:0], 32'hC0DE0000 | i, i[0], 3, 0));
    pending_cmds.push_back(mk(CMD_RESEND, 8'h10, 0, 16'h0002, 32'hBEEF, 1, 4, 0));
    pending_cmds.push_back(mk(CMD_CANCEL_FIRST, 8'h10, 1, 16'h0003, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_CANCEL_ALL, 8'h03, 1, 16'h0004, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_FLUSH, 8'h10, 1, 16'h0000, 0, 0, 0, 0));
    guard = 0;
    while ((pending_cmds.size() != 0 || expected_beats.size() != 0 || cmd_bus.valid)
           && guard < 100000) begin
      @(posedge clk_i); guard++;
    end
    // hold the sender while the first random batch is queued, then release it
    hold_send = 1'b1;
    for (int i = 0; i < 25; i++) pending_cmds.push_back(rand_cmd());
    repeat (30) @(posedge clk_i);
    hold_send = 1'b0;
    calm = 1'b1;
    for (int i = 0; i < 30; i++) pending_cmds.push_back(rand_cmd());
    while (pending_cmds.size() > 10) @(posedge clk_i);
    calm = 1'b0;
    for (int i = 0; i < 22; i++) pending_cmds.push_back(rand_cmd());
    guard = 0;
    while ((pending_cmds.size() != 0 || expected_beats.size() != 0 || cmd_bus.valid)
           && guard < 200000) begin
      @(posedge clk_i); guard++;
    end
    repeat (TIMERS + 8) @(posedge clk_i);
    if (errors == 0 && expected_beats.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end
endmodule

// File: filelist.f
design/mtt_pkg.sv
design/mtt_cmd_if.sv
design/mtt_res_if.sv
design/mtt_entry_ram.sv
design/message_timer_table_core.sv
test/message_timer_table_core_test.sv
